// File: rtl/bast_pkg.sv
// Package for the bounded array set table: sizes, operation codes and cell control word.
`default_nettype none
package bast_pkg;

  // Number of slots in the table.
  localparam int unsigned DEPTH = 16;

  // Widths that follow from the depth.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed widths of the interface fields.
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OCNT_W = 5;

  // Common width for comparing the count with the capacity register.
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Control word broadcast to every cell in the row.
  typedef struct packed {
    logic             do_add;
    logic             do_remove;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/bounded_array_set_table.sv
// Top level of the bounded array set table: cell row, count, capacity and result register.
`default_nettype none
// A packed multiset of up to DEPTH signed 32-bit values. A word is
// accepted when start_i is high (busy_o is always low, so a word may be
// issued every cycle) and its result appears on the cycle right after,
// with done_o high for exactly that one cycle. The receiver cannot stall, so
// the result must be captured when done_o is high. All slots compare against
// the word in parallel and the first-match flag ripples along the row of
// cells, which sets the clock period rather than the rate. The capacity
// register may be written only while no word is in flight; values above
// DEPTH act as DEPTH, and zero rejects every add.
module bounded_array_set_table (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire [1:0]                     operation_i,
  input  wire signed [bast_pkg::VAL_W-1:0] value_i,
  input  wire                           cfg_we_i,
  input  wire [bast_pkg::CAP_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [bast_pkg::OCNT_W-1:0]   count_o,
  output logic                          is_empty_o
);
  import bast_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q;
  logic              hit_q, hit_d;
  logic [OCNT_W-1:0] ocount_q;
  logic              empty_q;

  cell_ctrl_t        ctrl;
  logic [VAL_W-1:0]  entry   [DEPTH];
  logic [VAL_W-1:0]  next_in [DEPTH];
  logic              found   [DEPTH+1];
  logic              can_add;
  logic              remove_hit;
  logic              is_add, is_remove, is_query;

  // The table takes a word every cycle.
  assign busy_o = 1'b0;

  // Operation decode.
  always_comb begin
    is_add    = 1'b0;
    is_remove = 1'b0;
    is_query  = 1'b0;
    if (start_i) begin
      unique case (operation_i)
        OP_ADD:    is_add    = 1'b1;
        OP_REMOVE: is_remove = 1'b1;
        OP_QUERY:  is_query  = 1'b1;
        default:   ;
      endcase
    end
  end

  // Room is left when the count is below both the capacity and the depth.
  assign can_add = (CMP_W'(count_q) < CMP_W'(cap_q)) && (count_q < CNT_W'(DEPTH));

  // A cell only shifts at or above a match, so a remove with no match leaves the row alone.
  assign ctrl.do_add    = is_add && can_add;
  assign ctrl.do_remove = is_remove;
  assign ctrl.value     = value_i;
  assign ctrl.count     = count_q;

  assign remove_hit = is_remove && found[DEPTH];

  // Row of cells; each takes its upper neighbor's entry on a shift.
  assign found[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_last
      assign next_in[g] = entry[g];
    end else begin : g_mid
      assign next_in[g] = entry[g+1];
    end
    bast_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .idx_i        (IDX_W'(g)),
      .next_entry_i (next_in[g]),
      .found_i      (found[g]),
      .entry_o      (entry[g]),
      .found_o      (found[g+1])
    );
  end

  // Next count and hit flag.
  always_comb begin
    count_d = count_q;
    hit_d   = 1'b0;
    if (ctrl.do_add) begin
      count_d = count_q + CNT_W'(1);
      hit_d   = 1'b1;
    end else if (remove_hit) begin
      count_d = count_q - CNT_W'(1);
      hit_d   = 1'b1;
    end else if (is_query) begin
      hit_d   = found[DEPTH];
    end
  end

  // Control state: capacity, count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hit_q    <= hit_d;
      ocount_q <= OCNT_W'(count_d);
      empty_q  <= (count_d == '0);
    end
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign count_o    = ocount_q;
  assign is_empty_o = empty_q;

  // The count never runs past the number of slots.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count exceeds table depth");

  // Every accepted word yields a result on the next cycle.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_o)
    else $error("missing result after accepted word");

  // Without a word the contents count does not move.
  a_count_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> $stable(count_q))
    else $error("count changed without a word");

  // A hit on a remove or add moves the count by one.
  a_hit_moves_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.do_add || remove_hit) |=> (count_q != $past(count_q)))
    else $error("add or remove hit left the count unchanged");

endmodule
`default_nettype wire

// File: rtl/bast_cell.sv
// One slot of the table: holds an entry, compares it and shifts from its upper neighbor.
`default_nettype none
module bast_cell (
  input  wire                         clk_i,
  input  wire bast_pkg::cell_ctrl_t   ctrl_i,
  input  wire [bast_pkg::IDX_W-1:0]   idx_i,
  input  wire [bast_pkg::VAL_W-1:0]   next_entry_i,
  input  wire                         found_i,
  output logic [bast_pkg::VAL_W-1:0]  entry_o,
  output logic                        found_o
);
  import bast_pkg::*;

  logic [VAL_W-1:0] entry_q;
  logic [VAL_W-1:0] entry_d;
  logic [CNT_W-1:0] idx_ext;
  logic             occupied;
  logic             match;

  // Slot is live when its index is below the current count.
  assign idx_ext  = CNT_W'(idx_i);
  assign occupied = (idx_ext < ctrl_i.count);
  assign match    = occupied && (entry_q == ctrl_i.value);

  // A match here or in any lower slot is passed up the row.
  assign found_o = found_i | match;
  assign entry_o = entry_q;

  // Append at the first free slot, or shift down at and above the first match.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.do_add && (idx_ext == ctrl_i.count)) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.do_remove && found_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded array set table with its own table predictor.
module testbench;
  import bast_pkg::*;

  // The one operation code the package leaves unnamed.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Idle cycles in a row that count as a hung block.
  localparam int unsigned STALL_LIMIT = 2000;
  // A result follows its word on the next cycle.
  localparam int unsigned RESULT_LATENCY = 1;

  typedef struct packed {
    logic              hit;
    logic [OCNT_W-1:0] count;
    logic              is_empty;
  } table_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [1:0]              operation_i = OP_QUERY;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata_i = CAP_RESET;
  logic                    busy_o;
  logic                    done_o;
  logic                    hit_o;
  logic [OCNT_W-1:0]       count_o;
  logic                    is_empty_o;

  // Predicted contents of the table, slot 0 at the front.
  logic [VAL_W-1:0] held_values[$];
  logic [CAP_W-1:0] capacity_q = CAP_RESET;
  // Results predicted but not yet seen on the outputs.
  table_result_t    pending_results[$];

  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned capacity_writes = 0;
  int unsigned full_rejects = 0;
  int unsigned idle_cycles = 0;
  bit          idling_on = 1'b1;

  always #4 clk_i = ~clk_i;

  bounded_array_set_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  // Position of the first entry equal to the value, or -1.
  function automatic int find_first_slot(logic [VAL_W-1:0] v);
    for (int i = 0; i < held_values.size(); i++) begin
      if (held_values[i] == v) return i;
    end
    return -1;
  endfunction

  // Apply one word to the predicted table and return the result it should give.
  function automatic table_result_t apply_word(logic [1:0] op, logic [VAL_W-1:0] v);
    table_result_t r;
    int            pos;
    int unsigned   limit;
    limit = (capacity_q > DEPTH) ? DEPTH : capacity_q;
    pos   = find_first_slot(v);
    r.hit = 1'b0;
    case (op)
      OP_ADD: begin
        if (held_values.size() < limit) begin
          held_values.push_back(v);
          r.hit = 1'b1;
        end else begin
          full_rejects++;
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          held_values.delete(pos);
          r.hit = 1'b1;
        end
      end
      OP_QUERY: begin
        r.hit = (pos >= 0);
      end
      default: begin
        r.hit = 1'b0;
      end
    endcase
    r.count    = OCNT_W'(held_values.size());
    r.is_empty = (held_values.size() == 0);
    return r;
  endfunction

  // Hold the start line low for a number of cycles.
  task automatic pause_sender(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Issue one word, wait for it to be taken, then record its expected result.
  task automatic send_word(logic [1:0] op, logic [VAL_W-1:0] v);
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_word(op, v));
    words_sent++;
    if (idling_on && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 10));
  endtask

  // Stop sending until every expected result has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 1) @(posedge clk_i);
  endtask

  // Write the capacity register while the block is idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    capacity_q = cap;
    capacity_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Values mostly drawn from the table or a few edge values so that matches happen.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] edge_values[7];
    int unsigned      r;
    edge_values = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h5, 32'hFFFF_FFFB};
    r = $urandom_range(0, 9);
    if (r < 5 && held_values.size() > 0)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    if (r < 8) return edge_values[$urandom_range(0, 6)];
    return $urandom;
  endfunction

  // Operation mix that leans toward filling or toward emptying the table.
  function automatic logic [1:0] pick_operation(bit fill_bias);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= 95) return OP_UNUSED;
    if (r >= 75) return OP_QUERY;
    if (fill_bias) return (r < 55) ? OP_ADD : OP_REMOVE;
    return (r < 20) ? OP_ADD : OP_REMOVE;
  endfunction

  // Extreme values, duplicates, misses, first-match removal and the unused code.
  task automatic test_directed_ops();
    send_word(OP_QUERY, 32'h0);
    send_word(OP_REMOVE, 32'h0);
    send_word(OP_ADD, 32'h8000_0000);
    send_word(OP_ADD, 32'h7FFF_FFFF);
    send_word(OP_ADD, 32'h0);
    send_word(OP_ADD, 32'hFFFF_FFFF);
    send_word(OP_ADD, 32'h7FFF_FFFF);
    send_word(OP_QUERY, 32'h8000_0000);
    send_word(OP_REMOVE, 32'h7FFF_FFFF);
    send_word(OP_QUERY, 32'h7FFF_FFFF);
    send_word(OP_REMOVE, 32'h1234_5678);
    send_word(OP_UNUSED, 32'h0);
    send_word(OP_REMOVE, 32'h8000_0000);
    send_word(OP_REMOVE, 32'hFFFF_FFFF);
    send_word(OP_QUERY, 32'h0);
  endtask

  // Capacity lowered below the count, then zero capacity.
  task automatic test_capacity_limits();
    write_capacity(CAP_W'(1));
    send_word(OP_ADD, 32'h1);
    send_word(OP_REMOVE, 32'h0);
    send_word(OP_ADD, 32'h1);
    send_word(OP_REMOVE, 32'h7FFF_FFFF);
    send_word(OP_ADD, 32'h5);
    send_word(OP_ADD, 32'h6);
    write_capacity(CAP_W'(0));
    send_word(OP_ADD, 32'h7);
    send_word(OP_REMOVE, 32'h5);
    send_word(OP_ADD, 32'h8);
  endtask

  // One stretch of random traffic at a fixed capacity.
  task automatic run_random_phase(logic [CAP_W-1:0] cap, int unsigned n);
    write_capacity(cap);
    for (int unsigned i = 0; i < n; i++) begin
      send_word(pick_operation(((i / 40) % 2) == 0), pick_value());
      if (idling_on && i % 100 == 99 && $urandom_range(0, 1) == 0) wait_drained();
    end
  endtask

  // Random traffic across saturated, nominal, tiny, zero and random capacities.
  task automatic test_random_traffic();
    idling_on = 1'b1;
    run_random_phase(CAP_W'(31), 300);
    run_random_phase(CAP_W'(16), 300);
    run_random_phase(CAP_W'(1), 150);
    run_random_phase(CAP_W'(0), 100);
    run_random_phase(CAP_W'(17), 200);
    repeat (3) run_random_phase(CAP_W'($urandom_range(2, 15)), 150);
  endtask

  // Words on every cycle with no gaps.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    run_random_phase(CAP_W'(16), 150);
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("Result with no word outstanding: hit %0b count %0d empty %0b",
               hit_o, count_o, is_empty_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (hit_o !== want.hit) begin
          $error("hit: expected %0b, actual %0b", want.hit, hit_o);
          error_count++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count_o);
          error_count++;
        end
        if (is_empty_o !== want.is_empty) begin
          $error("is_empty: expected %0b, actual %0b", want.is_empty, is_empty_o);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Timeout: no word accepted and no result for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_capacity_limits();
    test_random_traffic();
    test_back_to_back();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    $display("Covered %0d words and %0d results over %0d capacity settings,",
             words_sent, results_checked, capacity_writes);
    $display("with %0d adds rejected at capacity and %0d mismatches.",
             full_rejects, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bast_pkg.sv
rtl/bast_cell.sv
rtl/bounded_array_set_table.sv
tb/testbench.sv
